FILE: sv/lmfqs_pkg.sv
// Shared constants, codes and word-packing helpers for the LED matrix frame queue scanner.
// No dependencies.
package lmfqs_pkg;

    localparam int FRAME_SLOTS = 8;
    localparam int SLOT_W      = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int CNT_W       = ($clog2(FRAME_SLOTS + 1) > 4) ? $clog2(FRAME_SLOTS + 1) : 4;
    localparam int PIX_W       = 8;
    localparam int Q_AW        = SLOT_W + PIX_W;
    localparam int Q_DEPTH     = FRAME_SLOTS * 256;
    localparam int S_AW        = 1 + PIX_W;
    localparam int S_DEPTH     = 512;

    localparam logic [2:0] KIND_PIXEL  = 3'd0;
    localparam logic [2:0] KIND_COMMIT = 3'd1;
    localparam logic [2:0] KIND_FRAME  = 3'd2;
    localparam logic [2:0] KIND_ROW    = 3'd3;
    localparam logic [2:0] KIND_FLUSH  = 3'd4;

    // Position of a word within its six-word pixel set.
    localparam logic [2:0] WORD_PAD  = 3'd0;
    localparam logic [2:0] WORD_P0   = 3'd1;
    localparam logic [2:0] WORD_P01  = 3'd2;
    localparam logic [2:0] WORD_P12  = 3'd3;
    localparam logic [2:0] WORD_P2   = 3'd4;
    localparam logic [2:0] WORD_LAST = 3'd5;

    // Repack one word: cur is the pixel just read, prev the one read before it.
    function automatic logic [31:0] pack_word(input logic [2:0] j, input logic [31:0] cur,
                                              input logic [31:0] prev);
        logic [31:0] w;
        case (j)
            WORD_PAD:  w = 32'd0;
            WORD_P0:   w = cur >> 20;
            WORD_P01:  w = (cur >> 24) | (prev << 12);
            WORD_P12:  w = (cur >> 28) | (prev << 8);
            WORD_P2:   w = cur << 4;
            WORD_LAST: w = cur;
            default:   w = 32'd0;
        endcase
        return w;
    endfunction

    // Pixel offset within the set to fetch while word j goes out.
    function automatic logic [1:0] fetch_offset(input logic [2:0] j);
        logic [1:0] o;
        case (j)
            WORD_PAD: o = 2'd0;
            WORD_P0:  o = 2'd1;
            WORD_P01: o = 2'd2;
            WORD_P12: o = 2'd2;
            default:  o = 2'd3;
        endcase
        return o;
    endfunction

    // Board wiring of the row decoder.
    function automatic logic [3:0] row_decode(input logic [3:0] r);
        logic [3:0] d;
        case (r)
            4'd0:  d = 4'd3;
            4'd1:  d = 4'd2;
            4'd2:  d = 4'd1;
            4'd3:  d = 4'd0;
            4'd4:  d = 4'd4;
            4'd5:  d = 4'd5;
            4'd6:  d = 4'd6;
            4'd7:  d = 4'd7;
            4'd8:  d = 4'd10;
            4'd9:  d = 4'd9;
            4'd10: d = 4'd8;
            4'd11: d = 4'd15;
            4'd12: d = 4'd11;
            4'd13: d = 4'd12;
            4'd14: d = 4'd13;
            default: d = 4'd14;
        endcase
        return d;
    endfunction

endpackage

FILE: sv/led_matrix_frame_queue_scanner_top.sv
// Top level of the LED matrix frame queue scanner: frame ring memory, display memory, sequencer.
// Depends on lmfqs_pkg.
//
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+--------------------------------------------
// command  | in        | start & !busy        | i_kind, i_pixel_index, i_pixel_value
// result   | out       | o_valid, one cycle   | o_is_drive_word .. o_refused
//
// Pixel write, commit, unused kinds: status item on the next cycle.
// Frame tick with work: one word copied per cycle over the ring memory read port.
// Row tick: four six-word sets, one drive word per cycle, set by the display memory read port.
// Flush and reset: clearing pass over the FRAME_SLOTS*256 (2048) ring entries, one entry of each
// memory per cycle; busy stays high. The receiver cannot stall: each item shows for one cycle.
module led_matrix_frame_queue_scanner_top
    import lmfqs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_pixel_index,
    input  logic [31:0] i_pixel_value,
    output logic        o_valid,
    output logic        o_is_drive_word,
    output logic [31:0] o_drive_word,
    output logic        o_last_of_row,
    output logic [3:0]  o_row_select,
    output logic [3:0]  o_frames_queued,
    output logic        o_queue_full,
    output logic        o_refused
);

    typedef enum logic [3:0] {
        ST_CLR  = 4'b0001,
        ST_IDLE = 4'b0010,
        ST_COPY = 4'b0100,
        ST_ROW  = 4'b1000
    } t_state;

    localparam logic [Q_AW-1:0]  Q_LAST    = Q_AW'(Q_DEPTH - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FRAME_SLOTS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(FRAME_SLOTS);

    logic [31:0] queued_mem [Q_DEPTH];
    logic [31:0] shown_mem  [S_DEPTH];

    t_state              r_state, n_state;
    logic [Q_AW-1:0]     r_clr;
    logic [SLOT_W-1:0]   r_fill, r_head;
    logic [CNT_W-1:0]    r_count;
    logic                r_active, r_swap;
    logic [3:0]          r_row;
    logic [8:0]          r_idx;
    logic                r_cp_v;
    logic [7:0]          r_cp_a;
    logic [1:0]          r_set;
    logic [2:0]          r_j;
    logic [31:0]         r_qdata, r_sdata, r_prev;

    logic                r_valid, r_is_word, r_last, r_refused;
    logic [31:0]         r_word;
    logic [3:0]          r_sel;

    logic                accept, full;
    logic                q_we, s_we;
    logic [Q_AW-1:0]     q_waddr, q_raddr;
    logic [31:0]         q_wdata, s_wdata;
    logic [S_AW-1:0]     s_waddr, s_raddr;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);
    assign full   = (r_count >= CNT_FULL);

    // Memory port selection: pixel writes when idle, copy with ring zero fill, zero fill in clearing.
    always_comb begin
        q_we    = 1'b0;
        q_waddr = {r_fill, i_pixel_index};
        q_wdata = i_pixel_value;
        s_we    = 1'b0;
        s_waddr = {~r_active, r_cp_a};
        s_wdata = r_qdata;
        q_raddr = {r_head, r_idx[7:0]};
        s_raddr = {r_active, r_row, ~r_set, fetch_offset(r_j)};
        n_state = r_state;
        case (r_state)
            ST_CLR: begin
                q_we    = 1'b1;
                q_waddr = r_clr;
                q_wdata = 32'd0;
                s_we    = 1'b1;
                s_waddr = r_clr[S_AW-1:0];
                s_wdata = 32'd0;
                if (r_clr == Q_LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        KIND_PIXEL:  q_we = !full;
                        KIND_FRAME:  if (r_count != '0 && !r_swap) n_state = ST_COPY;
                        KIND_ROW:    n_state = ST_ROW;
                        KIND_FLUSH:  n_state = ST_CLR;
                        default:     ;
                    endcase
                end
            end
            ST_COPY: begin
                if (r_cp_v) begin
                    q_we    = 1'b1;
                    q_waddr = {r_head, r_cp_a};
                    q_wdata = 32'd0;
                    s_we    = 1'b1;
                    if (r_cp_a == 8'hFF) n_state = ST_IDLE;
                end
            end
            ST_ROW: begin
                if (r_set == 2'd3 && r_j == WORD_LAST) n_state = ST_IDLE;
            end
            default: n_state = ST_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (q_we) queued_mem[q_waddr] <= q_wdata;
        r_qdata <= queued_mem[q_raddr];
        if (s_we) shown_mem[s_waddr] <= s_wdata;
        r_sdata <= shown_mem[s_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr   <= '0;
            r_fill  <= '0;
            r_head  <= '0;
            r_count <= '0;
            r_active <= 1'b0;
            r_swap  <= 1'b0;
            r_row   <= '0;
            r_idx   <= '0;
            r_cp_v  <= 1'b0;
            r_set   <= '0;
            r_j     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            r_cp_v  <= 1'b0;
            case (r_state)
                ST_CLR: begin
                    r_clr <= r_clr + 1'b1;
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_valid   <= (i_kind != KIND_ROW) &&
                                     !(i_kind == KIND_FRAME && r_count != '0 && !r_swap);
                        r_is_word <= 1'b0;
                        r_word    <= 32'd0;
                        r_last    <= 1'b0;
                        r_sel     <= 4'd0;
                        r_refused <= (i_kind == KIND_PIXEL || i_kind == KIND_COMMIT) && full;
                        r_idx     <= '0;
                        r_set     <= '0;
                        r_j       <= WORD_PAD;
                        case (i_kind)
                            KIND_COMMIT: begin
                                if (!full) begin
                                    r_fill  <= (r_fill == SLOT_LAST) ? '0 : r_fill + 1'b1;
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            KIND_FLUSH: begin
                                // Return all state to reset; the clearing pass wipes the memories.
                                r_clr    <= '0;
                                r_fill   <= '0;
                                r_head   <= '0;
                                r_count  <= '0;
                                r_active <= 1'b0;
                                r_swap   <= 1'b0;
                                r_row    <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_COPY: begin
                    // Read word idx now, write it to the hidden buffer next cycle.
                    if (!r_idx[8]) begin
                        r_idx  <= r_idx + 1'b1;
                        r_cp_v <= 1'b1;
                        r_cp_a <= r_idx[7:0];
                    end
                    if (r_cp_v && r_cp_a == 8'hFF) begin
                        r_head    <= (r_head == SLOT_LAST) ? '0 : r_head + 1'b1;
                        r_count   <= r_count - 1'b1;
                        r_swap    <= 1'b1;
                        r_valid   <= 1'b1;
                        r_is_word <= 1'b0;
                        r_word    <= 32'd0;
                        r_last    <= 1'b0;
                        r_sel     <= 4'd0;
                        r_refused <= 1'b0;
                    end
                end
                ST_ROW: begin
                    // Emit one word per cycle; the pixel fetched last cycle is in r_sdata.
                    r_prev    <= r_sdata;
                    r_valid   <= 1'b1;
                    r_is_word <= 1'b1;
                    r_word    <= pack_word(r_j, r_sdata, r_prev);
                    r_refused <= 1'b0;
                    r_last    <= 1'b0;
                    r_sel     <= 4'd0;
                    if (r_j == WORD_LAST) begin
                        r_j   <= WORD_PAD;
                        r_set <= r_set + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                    if (r_set == 2'd3 && r_j == WORD_LAST) begin
                        r_last <= 1'b1;
                        r_sel  <= row_decode(r_row);
                        if (r_swap && r_row == 4'd15) begin
                            r_active <= ~r_active;
                            r_swap   <= 1'b0;
                        end
                        r_row <= r_row + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid         = r_valid;
    assign o_is_drive_word = r_is_word;
    assign o_drive_word    = r_word;
    assign o_last_of_row   = r_last;
    assign o_row_select    = r_sel;
    assign o_frames_queued = r_count[3:0];
    assign o_queue_full    = full;
    assign o_refused       = r_refused;

endmodule

FILE: sv/lmfqs_checker.sv
// Port-level checks for the LED matrix frame queue scanner, bound to the top level.
// Depends on led_matrix_frame_queue_scanner_top.
module lmfqs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  i_kind,
    input logic [7:0]  i_pixel_index,
    input logic [31:0] i_pixel_value,
    input logic        o_valid,
    input logic        o_is_drive_word,
    input logic [31:0] o_drive_word,
    input logic        o_last_of_row,
    input logic [3:0]  o_row_select,
    input logic [3:0]  o_frames_queued,
    input logic        o_queue_full,
    input logic        o_refused
);

    a_last_is_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_row) |-> o_is_drive_word)
        else $error("row end without a drive word");

    a_sel_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_row_select != 4'd0) |-> o_last_of_row)
        else $error("row select outside row end");

    a_refuse_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_refused) |-> !o_is_drive_word)
        else $error("refusal on a drive word");

    a_mid_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_drive_word && !o_last_of_row) |-> busy)
        else $error("idle in the middle of a row");

    a_word_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_drive_word && !o_last_of_row) |=> (o_valid && o_is_drive_word))
        else $error("gap inside a row");

endmodule

bind led_matrix_frame_queue_scanner_top lmfqs_checker u_lmfqs_checker (.*);
